### rtl/core/vtf_pkg.sv
// Shared constants, codes and types of the port VLAN tag filter.
`timescale 1ns / 1ps
package vtf_pkg;

  localparam int unsigned NumPorts     = 32;
  localparam int unsigned MaxVlan      = 4095;
  localparam int unsigned BitmapWord   = 64;
  localparam int unsigned VidW         = 12;
  localparam int unsigned PortW        = 5;
  localparam int unsigned CountW       = 13;
  localparam int unsigned VidSpace     = 1 << VidW;
  localparam int unsigned WordsPerPort = (VidSpace + BitmapWord - 1) / BitmapWord;
  localparam int unsigned BitIdxW      = $clog2(BitmapWord);
  localparam int unsigned WordIdxW     = $clog2(WordsPerPort);
  localparam int unsigned PortIdxW     = $clog2(NumPorts);
  localparam int unsigned RamDepth     = NumPorts * WordsPerPort;
  localparam int unsigned RamAddrW     = PortIdxW + WordIdxW;

  localparam logic [2:0] OP_CONFIG  = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_INGRESS = 3'd3;
  localparam logic [2:0] OP_EGRESS  = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  localparam logic [1:0] KIND_ACCESS = 2'd0;
  localparam logic [1:0] KIND_TRUNK  = 2'd1;
  localparam logic [1:0] KIND_NATIVE = 2'd2;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_UNCONF    = 3'd1;
  localparam logic [2:0] STAT_INVALID   = 3'd2;
  localparam logic [2:0] STAT_NOT_TRUNK = 3'd3;
  localparam logic [2:0] STAT_MISMATCH  = 3'd4;
  localparam logic [2:0] STAT_UNTAGGED  = 3'd5;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_POP  = 2'd2;

  typedef struct packed {
    logic [2:0]      operation;
    logic [PortW-1:0] port;
    logic [1:0]      port_type;
    logic [VidW-1:0] vlan;
    logic            tagged_req;
    logic [VidW-1:0] tag_vid;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic [VidW-1:0] vlan_out;
    logic [1:0]      tag_action;
    logic [2:0]      status;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_CLEAR,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic clear_start;
    logic clear_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cfg_write;
    logic out_free;
    logic clear_last;
  } sts_t;

  function automatic logic vid_valid(input logic [VidW-1:0] v);
    return (v != '0) && (32'(v) <= MaxVlan);
  endfunction

endpackage

### rtl/core/vtf_if.sv
// Request and response channel interfaces of the port VLAN tag filter.
`timescale 1ns / 1ps
interface vtf_req_if import vtf_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vtf_rsp_if import vtf_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/vtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vtf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/vtf_ctrl.sv
// Sequencing state machine of the port VLAN tag filter.
`timescale 1ns / 1ps
module vtf_ctrl import vtf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  sts_t   sts_i,
  output cmd_t   cmd_o,
  output state_e state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.cfg_write) state_d = S_CLEAR;
        else if (sts_i.out_free) state_d = S_IDLE;
      end
      S_CLEAR: begin
        if (sts_i.clear_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECIDE: begin
        cmd_o.clear_start = sts_i.cfg_write;
        cmd_o.load_out    = !sts_i.cfg_write && sts_i.out_free;
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      S_FINISH: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

### rtl/core/vtf_dp.sv
// Port tables, member bitmap memory, decision logic and result register.
`timescale 1ns / 1ps
module vtf_dp import vtf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_data_o
);

  req_t                   item_q;
  logic [NumPorts-1:0]    valid_q;
  logic [1:0]             kind_q  [NumPorts];
  logic [VidW-1:0]        pvid_q  [NumPorts];
  logic [CountW-1:0]      count_q [NumPorts];
  logic                   rsp_valid_q;
  rsp_t                   rsp_q, rsp_d;
  logic [WordIdxW-1:0]    clr_cnt_q;

  logic [VidW-1:0]        in_vid, lk_vid;
  logic [PortIdxW-1:0]    idx;
  logic [WordIdxW-1:0]    lk_word;
  logic [BitIdxW-1:0]     lk_bit;
  logic [BitmapWord-1:0]  rdata, bit_mask, new_word;
  logic                   in_range, have, hit, allowed, cfg_good, seed, mem_upd;
  logic [1:0]             kind;
  logic [VidW-1:0]        pv;
  logic [CountW-1:0]      cnt, cnt_new;
  logic                   ram_we;
  logic [RamAddrW-1:0]    ram_waddr, ram_raddr;
  logic [BitmapWord-1:0]  ram_wdata;

  assign in_vid    = (req_data_i.operation == OP_INGRESS) ? req_data_i.tag_vid : req_data_i.vlan;
  assign ram_raddr = {req_data_i.port[PortIdxW-1:0], in_vid[VidW-1:BitIdxW]};

  assign lk_vid   = (item_q.operation == OP_INGRESS) ? item_q.tag_vid : item_q.vlan;
  assign lk_word  = lk_vid[VidW-1:BitIdxW];
  assign lk_bit   = lk_vid[BitIdxW-1:0];
  assign idx      = item_q.port[PortIdxW-1:0];
  assign in_range = 32'(item_q.port) < NumPorts;
  assign have     = in_range && valid_q[idx];
  assign kind     = kind_q[idx];
  assign pv       = pvid_q[idx];
  assign cnt      = count_q[idx];
  assign bit_mask = BitmapWord'(1) << lk_bit;
  assign hit      = rdata[lk_bit];
  assign allowed  = (cnt == '0) || hit;
  assign seed     = (item_q.port_type != KIND_ACCESS) && (item_q.vlan != '0);
  assign new_word = (item_q.operation == OP_ADD) ? (rdata | bit_mask) : (rdata & ~bit_mask);

  always_comb begin
    priority if (item_q.port_type == KIND_TRUNK) begin
      cfg_good = 32'(item_q.vlan) <= MaxVlan;
    end else if (item_q.port_type == KIND_ACCESS || item_q.port_type == KIND_NATIVE) begin
      cfg_good = vid_valid(item_q.vlan);
    end else begin
      cfg_good = 1'b0;
    end
  end

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = STAT_OK;
    mem_upd      = 1'b0;
    cnt_new      = cnt;
    priority if (item_q.operation > OP_QUERY) begin
      rsp_d.status = STAT_INVALID;
    end else if (item_q.operation == OP_ADD && !vid_valid(item_q.vlan)) begin
      rsp_d.status = STAT_INVALID;
    end else if (!in_range) begin
      rsp_d.status = STAT_UNCONF;
    end else if (item_q.operation == OP_CONFIG) begin
      if (cfg_good) rsp_d.ok = 1'b1;
      else rsp_d.status = STAT_INVALID;
    end else if (!have) begin
      rsp_d.status = STAT_UNCONF;
    end else if (item_q.operation == OP_ADD || item_q.operation == OP_REMOVE) begin
      if (kind == KIND_ACCESS) begin
        rsp_d.status = STAT_NOT_TRUNK;
      end else begin
        rsp_d.ok = 1'b1;
        mem_upd  = 1'b1;
        if (item_q.operation == OP_ADD && !hit) cnt_new = cnt + 1'b1;
        if (item_q.operation == OP_REMOVE && hit) cnt_new = cnt - 1'b1;
      end
    end else if (item_q.operation == OP_INGRESS) begin
      if (kind == KIND_ACCESS) begin
        if (!item_q.tagged_req) begin
          rsp_d.ok = 1'b1;
          rsp_d.vlan_out = pv;
          rsp_d.tag_action = ACT_PUSH;
        end else if (item_q.tag_vid == pv) begin
          rsp_d.ok = 1'b1;
          rsp_d.vlan_out = pv;
        end else begin
          rsp_d.status = STAT_MISMATCH;
        end
      end else if (item_q.tagged_req) begin
        if (allowed) begin
          rsp_d.ok = 1'b1;
          rsp_d.vlan_out = item_q.tag_vid;
        end else begin
          rsp_d.status = STAT_MISMATCH;
        end
      end else if (kind == KIND_NATIVE) begin
        rsp_d.ok = 1'b1;
        rsp_d.vlan_out = pv;
        rsp_d.tag_action = ACT_PUSH;
      end else begin
        rsp_d.status = STAT_UNTAGGED;
      end
    end else if (item_q.operation == OP_EGRESS) begin
      if ((kind == KIND_ACCESS || kind == KIND_NATIVE) && item_q.vlan == pv) begin
        rsp_d.ok = 1'b1;
        rsp_d.tag_action = item_q.tagged_req ? ACT_POP : ACT_NONE;
      end else if (kind == KIND_ACCESS) begin
        rsp_d.status = STAT_MISMATCH;
      end else if (item_q.tagged_req || item_q.vlan != '0) begin
        if (allowed) begin
          rsp_d.ok = 1'b1;
          rsp_d.tag_action = item_q.tagged_req ? ACT_NONE : ACT_PUSH;
        end else begin
          rsp_d.status = STAT_MISMATCH;
        end
      end else if (kind == KIND_TRUNK) begin
        rsp_d.status = STAT_UNTAGGED;
      end else begin
        rsp_d.status = STAT_MISMATCH;
      end
    end else begin
      priority if (kind == KIND_ACCESS) begin
        rsp_d.ok = item_q.vlan == pv;
      end else if (kind == KIND_TRUNK) begin
        rsp_d.ok = allowed;
      end else begin
        rsp_d.ok = (item_q.vlan == pv) || allowed;
      end
      if (!rsp_d.ok) rsp_d.status = STAT_MISMATCH;
    end
  end

  assign sts_o.cfg_write  = (item_q.operation == OP_CONFIG) && in_range && cfg_good;
  assign sts_o.out_free   = !rsp_valid_q || rsp_ready_i;
  assign sts_o.clear_last = clr_cnt_q == WordIdxW'(WordsPerPort - 1);

  assign ram_we    = cmd_i.clear_step || (cmd_i.load_out && mem_upd);
  assign ram_waddr = cmd_i.clear_step ? {idx, clr_cnt_q} : {idx, lk_word};
  assign ram_wdata = cmd_i.clear_step ?
                     ((seed && clr_cnt_q == lk_word) ? bit_mask : '0) : new_word;

  vtf_ram #(
    .Width (BitmapWord),
    .Depth (RamDepth)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= req_data_i;
    if (cmd_i.load_out) begin
      rsp_q <= rsp_d;
      if (sts_o.cfg_write) begin
        kind_q[idx]  <= item_q.port_type;
        pvid_q[idx]  <= item_q.vlan;
        count_q[idx] <= seed ? CountW'(1) : '0;
      end else if (mem_upd) begin
        count_q[idx] <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      if (cmd_i.load_out && sts_o.cfg_write) valid_q[idx] <= 1'b1;
      if (cmd_i.load_out) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
      if (cmd_i.clear_start) clr_cnt_q <= '0;
      else if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_q;

endmodule

### rtl/core/port_vlan_tag_filter_core.sv
// Per-port 802.1Q VLAN filter: top level joining controller and datapath.
// Sequence: an accepted item is captured with its bitmap word read, then decided and
// its result registered; a successful port configure runs decide, 64 bitmap row
// writes (clears that seed a nonzero PVID bit on trunk and native ports), finish.
// Input is held until the last result is loaded, also across output stalls.
// Reset: port valid flags and handshake state clear at once; bitmap rows are
// not cleared at reset but on each successful configure of their port.
`timescale 1ns / 1ps
module port_vlan_tag_filter_core import vtf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  vtf_req_if.sink    req_i,
  vtf_rsp_if.source  rsp_o
);

  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  vtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  vtf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_data_o  (rsp_o.data)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("item accepted while another is in flight");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("result overwrote an unread result");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == S_CLEAR) |-> (!req_i.ready && !cmd.load_out))
    else $error("activity during bitmap row clear");

  a_act_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.data.ok || rsp_o.data.tag_action == ACT_NONE))
    else $error("tag action on a dropped item");

endmodule

### sim/port_vlan_tag_filter_core_tb.sv
// Self-checking testbench of the port VLAN tag filter core, with directed and random items.
`timescale 1ns / 1ps
module port_vlan_tag_filter_core_tb;
  import vtf_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam bit   FIXED     = 1'b1;
  localparam bit   PREDICTED = 1'b0;
  localparam rsp_t NoRsp     = '0;

  localparam int DirRows      = 26;
  localparam int RandItems    = 650;
  localparam int QuietLimit   = 2000;
  localparam int DrainCycles  = 80;
  localparam int HoldCycles   = 120;
  localparam int PauseAt      = 250;
  localparam int HoldAt       = 400;

  typedef struct packed {
    req_t item;
    bit   fixed;
    rsp_t want;
  } vec_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vtf_req_if req_if ();
  vtf_rsp_if rsp_if ();

  port_vlan_tag_filter_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bit                  port_up   [NumPorts];
  logic [1:0]          port_mode [NumPorts];
  logic [VidW-1:0]     port_pvid [NumPorts];
  int unsigned         allow_cnt [NumPorts];
  bit [VidSpace-1:0]   allow_map [NumPorts];

  rsp_t        verdict_q [$];
  rsp_t        want_rsp;
  int unsigned mismatch_cnt = 0;
  bit          calm = 1'b0;
  bit          rsp_hold_req = 1'b0;
  int unsigned burst_left = 0;
  logic [VidW-1:0] vid_pool [8];

  vec_t dir_tab [DirRows] = '{
    {OP_QUERY,   5'd0,  KIND_ACCESS, 12'd0,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_UNCONF},
    {OP_RSVD6,   5'd0,  KIND_ACCESS, 12'd0,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_INVALID},
    {OP_RSVD7,   5'd31, KIND_BAD,    12'd4095, 1'b1, 12'd4095, FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_INVALID},
    {OP_ADD,     5'd3,  KIND_ACCESS, 12'd0,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_INVALID},
    {OP_REMOVE,  5'd3,  KIND_ACCESS, 12'd0,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_UNCONF},
    {OP_CONFIG,  5'd0,  KIND_BAD,    12'd5,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_INVALID},
    {OP_CONFIG,  5'd0,  KIND_ACCESS, 12'd0,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_INVALID},
    {OP_CONFIG,  5'd0,  KIND_NATIVE, 12'd0,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_INVALID},
    {OP_CONFIG,  5'd0,  KIND_ACCESS, 12'd4095, 1'b0, 12'd0,    FIXED, 1'b1, 12'd0, ACT_NONE,
     STAT_OK},
    {OP_INGRESS, 5'd0,  KIND_ACCESS, 12'd0,    1'b0, 12'd0,    FIXED, 1'b1, 12'd4095, ACT_PUSH,
     STAT_OK},
    {OP_INGRESS, 5'd0,  KIND_ACCESS, 12'd0,    1'b1, 12'd4095, FIXED, 1'b1, 12'd4095, ACT_NONE,
     STAT_OK},
    {OP_INGRESS, 5'd0,  KIND_ACCESS, 12'd0,    1'b1, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_MISMATCH},
    {OP_EGRESS,  5'd0,  KIND_ACCESS, 12'd4095, 1'b1, 12'd0,    FIXED, 1'b1, 12'd0, ACT_POP,
     STAT_OK},
    {OP_EGRESS,  5'd0,  KIND_ACCESS, 12'd1,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_MISMATCH},
    {OP_ADD,     5'd0,  KIND_ACCESS, 12'd4095, 1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_NOT_TRUNK},
    {OP_CONFIG,  5'd31, KIND_TRUNK,  12'd0,    1'b0, 12'd0,    FIXED, 1'b1, 12'd0, ACT_NONE,
     STAT_OK},
    {OP_INGRESS, 5'd31, KIND_ACCESS, 12'd0,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_UNTAGGED},
    {OP_EGRESS,  5'd31, KIND_ACCESS, 12'd0,    1'b0, 12'd0,    FIXED, 1'b0, 12'd0, ACT_NONE,
     STAT_UNTAGGED},
    {OP_INGRESS, 5'd31, KIND_ACCESS, 12'd0,    1'b1, 12'd0,    PREDICTED, NoRsp},
    {OP_ADD,     5'd31, KIND_ACCESS, 12'd4095, 1'b0, 12'd0,    PREDICTED, NoRsp},
    {OP_EGRESS,  5'd31, KIND_ACCESS, 12'd4094, 1'b0, 12'd0,    PREDICTED, NoRsp},
    {OP_REMOVE,  5'd31, KIND_ACCESS, 12'd100,  1'b0, 12'd0,    PREDICTED, NoRsp},
    {OP_EGRESS,  5'd31, KIND_ACCESS, 12'd4095, 1'b0, 12'd0,    PREDICTED, NoRsp},
    {OP_CONFIG,  5'd5,  KIND_NATIVE, 12'd1,    1'b0, 12'd0,    PREDICTED, NoRsp},
    {OP_EGRESS,  5'd5,  KIND_ACCESS, 12'd0,    1'b0, 12'd0,    PREDICTED, NoRsp},
    {OP_QUERY,   5'd31, KIND_ACCESS, 12'd4095, 1'b0, 12'd0,    PREDICTED, NoRsp}
  };

  function automatic bit vid_permitted(input logic [PortW-1:0] p, input logic [VidW-1:0] v);
    return (allow_cnt[p] == 0) || allow_map[p][v];
  endfunction

  function automatic rsp_t filter_verdict(input req_t r);
    rsp_t            res;
    logic [PortW-1:0] p;
    logic [VidW-1:0] v;
    logic [VidW-1:0] pvid;
    logic [1:0]      kind;
    logic [1:0]      act_sel;
    bit              carry;
    bit              hit;
    res  = '0;
    p    = r.port;
    v    = r.vlan;
    kind = port_mode[p];
    pvid = port_pvid[p];
    if (r.operation > OP_QUERY) begin
      res.status = STAT_INVALID;
    end else if (r.operation == OP_ADD && v == '0) begin
      res.status = STAT_INVALID;
    end else if (r.operation == OP_CONFIG) begin
      if (r.port_type == KIND_BAD || (r.port_type != KIND_TRUNK && v == '0)) begin
        res.status = STAT_INVALID;
      end else begin
        port_up[p]   = 1'b1;
        port_mode[p] = r.port_type;
        port_pvid[p] = v;
        allow_map[p] = '0;
        allow_cnt[p] = 0;
        if (r.port_type != KIND_ACCESS && v != '0) begin
          allow_map[p][v] = 1'b1;
          allow_cnt[p]    = 1;
        end
        res.ok = 1'b1;
      end
    end else if (!port_up[p]) begin
      res.status = STAT_UNCONF;
    end else begin
      case (r.operation)
        OP_ADD, OP_REMOVE: begin
          if (kind == KIND_ACCESS) begin
            res.status = STAT_NOT_TRUNK;
          end else begin
            if (allow_map[p][v] != (r.operation == OP_ADD)) begin
              allow_map[p][v] = (r.operation == OP_ADD);
              if (r.operation == OP_ADD) allow_cnt[p]++;
              else allow_cnt[p]--;
            end
            res.ok = 1'b1;
          end
        end
        OP_INGRESS: begin
          if (kind == KIND_ACCESS) begin
            if (!r.tagged_req) begin
              res.ok = 1'b1;
              res.vlan_out = pvid;
              res.tag_action = ACT_PUSH;
            end else if (r.tag_vid == pvid) begin
              res.ok = 1'b1;
              res.vlan_out = pvid;
            end else begin
              res.status = STAT_MISMATCH;
            end
          end else if (r.tagged_req) begin
            if (vid_permitted(p, r.tag_vid)) begin
              res.ok = 1'b1;
              res.vlan_out = r.tag_vid;
            end else begin
              res.status = STAT_MISMATCH;
            end
          end else if (kind == KIND_NATIVE) begin
            res.ok = 1'b1;
            res.vlan_out = pvid;
            res.tag_action = ACT_PUSH;
          end else begin
            res.status = STAT_UNTAGGED;
          end
        end
        OP_EGRESS: begin
          if (kind != KIND_TRUNK && v == pvid) begin
            res.ok = 1'b1;
            res.tag_action = r.tagged_req ? ACT_POP : ACT_NONE;
          end else if (kind == KIND_ACCESS) begin
            res.status = STAT_MISMATCH;
          end else begin
            carry   = r.tagged_req;
            act_sel = ACT_NONE;
            if (!carry && v != '0) begin
              carry   = 1'b1;
              act_sel = ACT_PUSH;
            end
            if (carry && vid_permitted(p, v)) begin
              res.ok = 1'b1;
              res.tag_action = act_sel;
            end else if (!carry && kind == KIND_TRUNK) begin
              res.status = STAT_UNTAGGED;
            end else begin
              res.status = STAT_MISMATCH;
            end
          end
        end
        default: begin
          if (kind == KIND_ACCESS) hit = (v == pvid);
          else if (kind == KIND_TRUNK) hit = vid_permitted(p, v);
          else hit = (v == pvid) || vid_permitted(p, v);
          if (hit) res.ok = 1'b1;
          else res.status = STAT_MISMATCH;
        end
      endcase
    end
    return res;
  endfunction

  function automatic logic [VidW-1:0] pick_vid();
    int unsigned w;
    w = $urandom_range(0, 9);
    if (w < 6) return vid_pool[$urandom_range(0, 7)];
    if (w == 6) return '0;
    if (w == 7) return 12'd4095;
    return VidW'($urandom_range(0, 4095));
  endfunction

  task automatic drive_item(input req_t item, input bit fixed, input rsp_t fixed_rsp);
    int unsigned gap;
    rsp_t        verdict;
    gap = (calm || burst_left != 0) ? 0 : $urandom_range(0, 10);
    if (burst_left != 0) burst_left--;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk_i); while (!req_if.ready);
    verdict = filter_verdict(item);
    verdict_q.push_back(fixed ? fixed_rsp : verdict);
  endtask

  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rsp_hold_req) begin
        stall = HoldCycles;
        rsp_hold_req = 1'b0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (verdict_q.size() == 0) begin
        $error("result with no item pending: %p", rsp_if.data);
        mismatch_cnt++;
      end else begin
        want_rsp = verdict_q.pop_front();
        if (rsp_if.data.ok !== want_rsp.ok) begin
          $error("ok: expected %0d, got %0d", want_rsp.ok, rsp_if.data.ok);
          mismatch_cnt++;
        end
        if (rsp_if.data.vlan_out !== want_rsp.vlan_out) begin
          $error("vlan_out: expected %0d, got %0d", want_rsp.vlan_out, rsp_if.data.vlan_out);
          mismatch_cnt++;
        end
        if (rsp_if.data.tag_action !== want_rsp.tag_action) begin
          $error("tag_action: expected %0d, got %0d", want_rsp.tag_action,
                 rsp_if.data.tag_action);
          mismatch_cnt++;
        end
        if (rsp_if.data.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, rsp_if.data.status);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("port_vlan_tag_filter_core regression: fail");
    $finish;
  end

  initial begin
    req_t        item;
    int unsigned w;
    int          i;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    for (i = 0; i < NumPorts; i++) begin
      port_up[i]   = 1'b0;
      port_mode[i] = KIND_ACCESS;
      port_pvid[i] = '0;
      allow_cnt[i] = 0;
      allow_map[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) begin
      drive_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);
    end

    vid_pool[0] = 12'd1;
    vid_pool[1] = 12'd4095;
    for (i = 2; i < 8; i++) vid_pool[i] = VidW'($urandom_range(1, 4094));

    for (i = 0; i < RandItems; i++) begin
      calm = (i >= 100 && i < 160);
      if (i == PauseAt) begin
        req_if.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk_i);
      end
      if (i == HoldAt) begin
        rsp_hold_req = 1'b1;
        burst_left   = 40;
      end
      w = $urandom_range(0, 99);
      if (w < 10) item.operation = OP_CONFIG;
      else if (w < 30) item.operation = OP_ADD;
      else if (w < 40) item.operation = OP_REMOVE;
      else if (w < 60) item.operation = OP_INGRESS;
      else if (w < 80) item.operation = OP_EGRESS;
      else if (w < 96) item.operation = OP_QUERY;
      else if (w < 98) item.operation = OP_RSVD6;
      else item.operation = OP_RSVD7;
      item.port       = ($urandom_range(0, 3) != 0) ? PortW'($urandom_range(0, 3))
                                                    : PortW'($urandom_range(0, 31));
      item.port_type  = 2'($urandom_range(0, 3));
      item.vlan       = pick_vid();
      item.tagged_req = 1'($urandom_range(0, 1));
      item.tag_vid    = pick_vid();
      drive_item(item, PREDICTED, NoRsp);
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("port_vlan_tag_filter_core regression: pass");
    end else begin
      $display("port_vlan_tag_filter_core regression: fail");
    end
    $finish;
  end

endmodule
